[rtl/global_alignment_score_linear_top_defines.svh]
// ---------------------------------------------------------------------------
// alignment score block assertion macros
// shared concurrent assertion forms, clocked on clk, off during reset
// ---------------------------------------------------------------------------
`ifndef GLOBAL_ALIGNMENT_SCORE_LINEAR_TOP_DEFINES_SVH
`define GLOBAL_ALIGNMENT_SCORE_LINEAR_TOP_DEFINES_SVH

// same-cycle implication
`define GASL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GASL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/gasl_pkg.sv]
// ---------------------------------------------------------------------------
// alignment score package
// sizes, opcodes and payload types shared by the alignment score block
// ---------------------------------------------------------------------------
`default_nettype none

package gasl_pkg;

    localparam int MAX_LEN  = 1024;
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int REF_AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SCORE_W  = 20;
    localparam int SYM_W    = 8;
    localparam int CFG_W    = 8;
    localparam int CFG_AW   = 2;

    localparam logic [1:0] OP_LOAD_REF = 2'd0;
    localparam logic [1:0] OP_QUERY    = 2'd1;
    localparam logic [1:0] OP_EMIT     = 2'd2;

    localparam logic [CFG_AW-1:0] REG_MATCH    = 2'd0;
    localparam logic [CFG_AW-1:0] REG_GAP      = 2'd1;
    localparam logic [CFG_AW-1:0] REG_MISMATCH = 2'd2;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [SYM_W-1:0] symbol;
    } item_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      error;
    } result_t;

    typedef struct packed {
        logic signed [CFG_W-1:0] match_score;
        logic signed [CFG_W-1:0] gap_score;
        logic signed [CFG_W-1:0] mismatch_score;
    } score_cfg_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] diag;
        logic signed [SCORE_W-1:0] up;
        logic signed [SCORE_W-1:0] left;
        logic [SYM_W-1:0]          ref_sym;
        logic [SYM_W-1:0]          qry_sym;
    } cell_in_t;

endpackage

`default_nettype wire

[rtl/gasl_ram.sv]
// ---------------------------------------------------------------------------
// simple dual-port ram
// one write port, one read port, registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module gasl_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    parameter int AW    = 10
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/gasl_cell.sv]
// ---------------------------------------------------------------------------
// alignment score cell
// one matrix cell: best of diagonal, upper and left moves, saturated
// ---------------------------------------------------------------------------
`default_nettype none

module gasl_cell
    import gasl_pkg::*;
(
    input  wire cell_in_t                   cell_in,
    input  wire score_cfg_t                 cfg,
    output logic signed [SCORE_W-1:0]       best
);

    localparam logic signed [SCORE_W-1:0] S_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] S_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    function automatic logic signed [SCORE_W-1:0] sat(input logic signed [SCORE_W:0] v);
        logic signed [SCORE_W-1:0] r;
        if (v[SCORE_W] != v[SCORE_W-1])
        begin
            r = v[SCORE_W] ? S_MIN : S_MAX;
        end
        else
        begin
            r = v[SCORE_W-1:0];
        end
        return r;
    endfunction

    logic signed [CFG_W-1:0]   sub;
    logic signed [SCORE_W:0]   sub_ext;
    logic signed [SCORE_W:0]   gap_ext;
    logic signed [SCORE_W-1:0] from_diag;
    logic signed [SCORE_W-1:0] from_up;
    logic signed [SCORE_W-1:0] from_left;
    logic signed [SCORE_W-1:0] best_du;

    assign sub     = (cell_in.ref_sym == cell_in.qry_sym) ? cfg.match_score
                                                          : cfg.mismatch_score;
    assign sub_ext = (SCORE_W+1)'(sub);
    assign gap_ext = (SCORE_W+1)'(cfg.gap_score);

    assign from_diag = sat((SCORE_W+1)'(cell_in.diag) + sub_ext);
    assign from_up   = sat((SCORE_W+1)'(cell_in.up) + gap_ext);
    assign from_left = sat((SCORE_W+1)'(cell_in.left) + gap_ext);

    assign best_du = (from_up > from_diag) ? from_up : from_diag;
    assign best    = (from_left > best_du) ? from_left : best_du;

endmodule

`default_nettype wire

[rtl/global_alignment_score_linear_top.sv]
// ---------------------------------------------------------------------------
// global alignment score, linear gap, linear space
// loads a reference, sweeps a stored score row per query symbol, emits score
// ---------------------------------------------------------------------------
// Timing: one item at a time. A reference symbol (opcode 0), a dropped symbol
// or opcode 3 is handled in the idle state alone. A query symbol (opcode 1)
// reads the old column zero when accepted and rewrites it in the start state,
// then sweeps one column a cycle through the score row ram, reading the next
// column's old score while the current one is written. An emit (opcode 2)
// reads the final column, then waits for the result register to drain.
// Neither ram is cleared after reset, so no item waits on a clearing
// pass; row zero is produced on the fly during the first query sweep.
// ---------------------------------------------------------------------------
`default_nettype none

`include "global_alignment_score_linear_top_defines.svh"

module global_alignment_score_linear_top
    import gasl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    // configuration write port
    input  wire logic              cfg_we,
    input  wire logic [CFG_AW-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]  cfg_wdata,

    // item channel
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire item_t             item_data,

    // result channel
    output logic                   result_valid,
    input  wire logic              result_stall,
    output result_t                result_data
);

    // sequencer codes
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_COL   = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);
    localparam int PROD_W = CFG_W + LEN_W + 1;

    logic [1:0]                state_reg;
    logic [1:0]                state_next;

    score_cfg_t                cfg_reg;

    logic [LEN_W-1:0]          ref_len_reg;
    logic [LEN_W-1:0]          qlen_reg;
    logic                      err_reg;
    logic                      first_reg;
    logic [SYM_W-1:0]          sym_reg;
    logic [LEN_W-1:0]          j_reg;
    logic signed [SCORE_W-1:0] diag_reg;
    logic signed [SCORE_W-1:0] left_reg;
    logic signed [SCORE_W-1:0] acc_reg;
    logic signed [SCORE_W-1:0] prod_reg;

    logic                      result_valid_reg;
    result_t                   result_data_reg;

    logic                      item_accept;
    logic                      result_accept;
    logic                      can_load;
    logic                      last_col;

    // gap times a length, shared by column zero and the empty-query score
    logic [LEN_W-1:0]          mul_len;
    logic signed [PROD_W-1:0]  mul_full;

    // ram ports
    logic                      ref_we;
    logic                      ref_re;
    logic [REF_AW-1:0]         ref_raddr;
    logic [SYM_W-1:0]          ref_rdata;
    logic                      row_we;
    logic [LEN_W-1:0]          row_waddr;
    logic signed [SCORE_W-1:0] row_wdata;
    logic                      row_re;
    logic [LEN_W-1:0]          row_raddr;
    logic [SCORE_W-1:0]        row_rdata;

    cell_in_t                  cell_in;
    logic signed [SCORE_W-1:0] cell_best;
    logic signed [SCORE_W-1:0] up_val;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign item_stall    = (state_reg != ST_IDLE);
    assign item_accept   = item_valid && !item_stall;
    assign result_accept = result_valid_reg && !result_stall;
    assign can_load      = !result_valid_reg || !result_stall;
    assign result_valid  = result_valid_reg;
    assign result_data   = result_data_reg;

    assign last_col = (j_reg == ref_len_reg);

    // first query sweep takes row zero from a running gap sum
    assign up_val = first_reg ? acc_reg : $signed(row_rdata);

    // ------------------------------------------------------------------
    // shared multiplier, registered before use
    // ------------------------------------------------------------------
    assign mul_len  = (item_data.opcode == OP_QUERY) ? (qlen_reg + LEN_W'(1)) : ref_len_reg;
    assign mul_full = PROD_W'(cfg_reg.gap_score) * PROD_W'($signed({1'b0, mul_len}));

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    if (item_data.opcode == OP_QUERY && qlen_reg != LEN_MAX)
                    begin
                        state_next = ST_START;
                    end
                    else if (item_data.opcode == OP_EMIT)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_START:
            begin
                state_next = (ref_len_reg == '0) ? ST_IDLE : ST_COL;
            end
            ST_COL:
            begin
                if (last_col)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // ram control
    // ------------------------------------------------------------------
    always_comb
    begin
        ref_we    = 1'b0;
        ref_re    = 1'b0;
        ref_raddr = '0;
        row_we    = 1'b0;
        row_waddr = '0;
        row_wdata = cell_best;
        row_re    = 1'b0;
        row_raddr = '0;
        case (state_reg)
            ST_IDLE:
            begin
                ref_we = item_accept && (item_data.opcode == OP_LOAD_REF)
                         && (qlen_reg == '0) && (ref_len_reg != LEN_MAX);
                // old column zero for a query, final column for an emit
                if (item_accept && item_data.opcode == OP_EMIT)
                begin
                    row_re    = 1'b1;
                    row_raddr = ref_len_reg;
                end
                else if (item_accept && item_data.opcode == OP_QUERY)
                begin
                    row_re    = 1'b1;
                    row_raddr = '0;
                end
            end
            ST_START:
            begin
                row_we    = 1'b1;
                row_waddr = '0;
                row_wdata = prod_reg;
                if (ref_len_reg != '0)
                begin
                    row_re    = 1'b1;
                    row_raddr = LEN_W'(1);
                    ref_re    = 1'b1;
                    ref_raddr = '0;
                end
            end
            ST_COL:
            begin
                row_we    = 1'b1;
                row_waddr = j_reg;
                if (!last_col)
                begin
                    row_re    = 1'b1;
                    row_raddr = j_reg + LEN_W'(1);
                    ref_re    = 1'b1;
                    ref_raddr = j_reg[REF_AW-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    gasl_ram #(
        .DEPTH (MAX_LEN),
        .WIDTH (SYM_W),
        .AW    (REF_AW)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ref_len_reg[REF_AW-1:0]),
        .wdata (item_data.symbol),
        .re    (ref_re),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    gasl_ram #(
        .DEPTH (MAX_LEN + 1),
        .WIDTH (SCORE_W),
        .AW    (LEN_W)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (row_re),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    // ------------------------------------------------------------------
    // column cell
    // ------------------------------------------------------------------
    assign cell_in.diag    = diag_reg;
    assign cell_in.up      = up_val;
    assign cell_in.left    = left_reg;
    assign cell_in.ref_sym = ref_rdata;
    assign cell_in.qry_sym = sym_reg;

    gasl_cell u_cell (
        .cell_in (cell_in),
        .cfg     (cfg_reg),
        .best    (cell_best)
    );

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.match_score    <= 8'sd1;
            cfg_reg.gap_score      <= -8'sd4;
            cfg_reg.mismatch_score <= -8'sd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MATCH:    cfg_reg.match_score    <= cfg_wdata;
                REG_GAP:      cfg_reg.gap_score      <= cfg_wdata;
                REG_MISMATCH: cfg_reg.mismatch_score <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ref_len_reg      <= '0;
            qlen_reg         <= '0;
            err_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (result_accept)
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (item_accept)
                    begin
                        case (item_data.opcode)
                            OP_LOAD_REF:
                            begin
                                // late or overflowing reference symbol is dropped
                                if (qlen_reg != '0 || ref_len_reg == LEN_MAX)
                                begin
                                    err_reg <= 1'b1;
                                end
                                else
                                begin
                                    ref_len_reg <= ref_len_reg + LEN_W'(1);
                                end
                            end
                            OP_QUERY:
                            begin
                                if (qlen_reg == LEN_MAX)
                                begin
                                    err_reg <= 1'b1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_START:
                begin
                    qlen_reg <= qlen_reg + LEN_W'(1);
                end
                ST_EMIT:
                begin
                    if (can_load)
                    begin
                        result_valid_reg <= 1'b1;
                        ref_len_reg      <= '0;
                        qlen_reg         <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // datapath registers, no reset needed
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    prod_reg  <= SCORE_W'(mul_full);
                    sym_reg   <= item_data.symbol;
                    first_reg <= (qlen_reg == '0);
                end
            end
            ST_START:
            begin
                // old column zero becomes the first diagonal, zero on the first sweep
                diag_reg <= first_reg ? '0 : $signed(row_rdata);
                left_reg <= prod_reg;
                acc_reg  <= SCORE_W'(cfg_reg.gap_score);
                j_reg    <= LEN_W'(1);
            end
            ST_COL:
            begin
                left_reg <= cell_best;
                diag_reg <= up_val;
                acc_reg  <= acc_reg + SCORE_W'(cfg_reg.gap_score);
                j_reg    <= j_reg + LEN_W'(1);
            end
            ST_EMIT:
            begin
                if (can_load)
                begin
                    result_data_reg.score <= first_reg ? prod_reg : $signed(row_rdata);
                    result_data_reg.error <= err_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `GASL_ASSERT_NOW(a_col_in_range, state_reg == ST_COL,
        j_reg != '0 && j_reg <= ref_len_reg, "column pointer outside the reference")
    `GASL_ASSERT_NOW(a_len_bound, 1'b1,
        ref_len_reg <= LEN_MAX && qlen_reg <= LEN_MAX, "sequence length beyond maximum")
    `GASL_ASSERT_NEXT(a_emit_clears, state_reg == ST_EMIT && can_load,
        result_valid_reg && ref_len_reg == '0 && qlen_reg == '0, "emit did not clear lengths")
    `GASL_ASSERT_NEXT(a_err_sticky, err_reg, err_reg, "error flag cleared")
    `GASL_ASSERT_NOW(a_no_ref_after_query, ref_we, qlen_reg == '0,
        "reference written after query start")

endmodule

`default_nettype wire
